// ===== sv/ogtr_pkg.sv =====
// ----------------------------------------------------------------------------
// ogtr_pkg: shared types and constants
// Map limits, tile limits, register indexes, cell codes and the request,
// operation and result records passed between the front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package ogtr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int TILE_CELLS = 64;

    localparam int TILE_SIDE  = 8;
    localparam int TILE_LIM_W = (TILE_SIDE < TILE_CELLS) ? TILE_SIDE : TILE_CELLS;

    localparam int TH_LIM_1 = (TILE_CELLS / 1 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 1;
    localparam int TH_LIM_2 = (TILE_CELLS / 2 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 2;
    localparam int TH_LIM_3 = (TILE_CELLS / 3 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 3;
    localparam int TH_LIM_4 = (TILE_CELLS / 4 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 4;
    localparam int TH_LIM_5 = (TILE_CELLS / 5 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 5;
    localparam int TH_LIM_6 = (TILE_CELLS / 6 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 6;
    localparam int TH_LIM_7 = (TILE_CELLS / 7 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 7;
    localparam int TH_LIM_8 = (TILE_CELLS / 8 > TILE_SIDE) ? TILE_SIDE : TILE_CELLS / 8;

    localparam int DIM_W   = 9;
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PROD_W  = DIM_W + ROW_W;
    localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int GRID_AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

    localparam int POS_W   = 9;
    localparam int TPOS_W  = POS_W + 1;
    localparam int TSIZE_W = 4;
    localparam int OFS_W   = 3;
    localparam int CHAN_W  = 8;
    localparam int CNT_W   = 3;
    localparam int SUM_W   = CHAN_W + 2;
    localparam int THR_W   = SUM_W + 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

    localparam logic [DIM_W-1:0] MAP_SIZE_RESET = 9'd256;
    localparam logic [CNT_W-1:0] CHANNELS_RESET = 3'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TILE = 1'b1;

    typedef logic [1:0] cell_code_t;
    localparam cell_code_t CELL_UNKNOWN = 2'b00;
    localparam cell_code_t CELL_OCC     = 2'b01;
    localparam cell_code_t CELL_FREE    = 2'b11;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } map_dims_t;

    typedef struct packed {
        logic               is_tile;
        cell_code_t         code;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [TSIZE_W-1:0] tw;
        logic [TSIZE_W-1:0] th;
    } cmd_t;

    typedef struct packed {
        logic              is_write;
        cell_code_t        code;
        logic              off;
        logic              last;
        logic [OFS_W-1:0]  cx;
        logic [OFS_W-1:0]  cy;
        logic [TPOS_W-1:0] x;
        logic [TPOS_W-1:0] y;
    } op_t;

    typedef struct packed {
        logic             last;
        logic             off;
        logic [OFS_W-1:0] cy;
        logic [OFS_W-1:0] cx;
        cell_code_t       value;
    } res_t;

    function automatic logic [TSIZE_W-1:0] tile_h_limit(input logic [TSIZE_W-1:0] tw);
        logic [TSIZE_W-1:0] lim;
        unique case (tw)
            4'd1:    lim = TSIZE_W'(TH_LIM_1);
            4'd2:    lim = TSIZE_W'(TH_LIM_2);
            4'd3:    lim = TSIZE_W'(TH_LIM_3);
            4'd4:    lim = TSIZE_W'(TH_LIM_4);
            4'd5:    lim = TSIZE_W'(TH_LIM_5);
            4'd6:    lim = TSIZE_W'(TH_LIM_6);
            4'd7:    lim = TSIZE_W'(TH_LIM_7);
            4'd8:    lim = TSIZE_W'(TH_LIM_8);
            default: lim = '0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ogtr_ram.sv =====
// ----------------------------------------------------------------------------
// ogtr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ogtr_ram #(
    parameter int   WIDTH = 2,
    parameter int   DEPTH = 65536,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/ogtr_front.sv =====
// ----------------------------------------------------------------------------
// ogtr_front: request intake and pixel classification
// Holds the configuration registers and the load position, classifies load
// pixels, clamps tile windows and pushes requests into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ogtr_front import ogtr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output map_dims_t                  dims,
    output logic                       q_push,
    output cmd_t                       q_data,
    input  wire logic                  q_ready
);

    logic               negate_reg;
    logic [CNT_W-1:0]   chan_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic [CHAN_W-1:0]  ch0, ch1, ch2, ch3;
    logic [POS_W-1:0]   tile_col, tile_row;
    logic [TSIZE_W-1:0] tw_in, th_in, tw_c, th_lim, th_c;
    logic [CNT_W-1:0]   n_eff;
    logic [SUM_W-1:0]   sum;
    logic [THR_W-1:0]   s4, s2, n_ext;
    cell_code_t         code;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic               accept, load_acc;

    assign ch0      = s_tdata[0 +: CHAN_W];
    assign ch1      = s_tdata[8 +: CHAN_W];
    assign ch2      = s_tdata[16 +: CHAN_W];
    assign ch3      = s_tdata[24 +: CHAN_W];
    assign tile_col = s_tdata[32 +: POS_W];
    assign tile_row = s_tdata[41 +: POS_W];
    assign tw_in    = s_tdata[50 +: TSIZE_W];
    assign th_in    = s_tdata[54 +: TSIZE_W];

    always_comb begin
        dims.w = (width_reg == '0) ? DIM_W'(1) :
                 (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        dims.h = (height_reg == '0) ? DIM_W'(1) :
                 (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    end

    always_comb begin
        n_eff = (chan_reg == '0) ? CNT_W'(1) : (chan_reg > CNT_W'(4)) ? CNT_W'(4) : chan_reg;
        sum   = SUM_W'(ch0)
              + ((n_eff >= CNT_W'(2)) ? SUM_W'(ch1) : '0)
              + ((n_eff >= CNT_W'(3)) ? SUM_W'(ch2) : '0)
              + ((n_eff >= CNT_W'(4)) ? SUM_W'(ch3) : '0);
        s4    = {sum, 2'b00};
        s2    = {1'b0, sum, 1'b0};
        n_ext = THR_W'(n_eff);
        code  = CELL_UNKNOWN;
        if (negate_reg) begin
            if (s4 > THR_W'(969) * n_ext) begin
                code = CELL_OCC;
            end else if (s2 < THR_W'(51) * n_ext) begin
                code = CELL_FREE;
            end
        end else begin
            if (s4 < THR_W'(51) * n_ext) begin
                code = CELL_OCC;
            end else if (s2 > THR_W'(459) * n_ext) begin
                code = CELL_FREE;
            end
        end
    end

    always_comb begin
        tw_c   = (tw_in > TSIZE_W'(TILE_LIM_W)) ? TSIZE_W'(TILE_LIM_W) : tw_in;
        th_lim = tile_h_limit(tw_c);
        th_c   = (th_in > th_lim) ? th_lim : th_in;
    end

    always_comb begin
        q_data.is_tile = (s_tuser == MODE_TILE);
        q_data.code    = code;
        q_data.tw      = tw_c;
        q_data.th      = th_c;
        if (s_tuser == MODE_LOAD) begin
            q_data.x = POS_W'(col_reg);
            q_data.y = POS_W'(dims.h - DIM_W'(1) - DIM_W'(row_reg));
        end else begin
            q_data.x = tile_col;
            q_data.y = tile_row;
        end
    end

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign load_acc = accept && (s_tuser == MODE_LOAD);
    assign q_push   = accept && ((s_tuser == MODE_LOAD) || (tw_c != '0 && th_c != '0));

    always_comb begin
        col_inc  = DIM_W'(col_reg) + DIM_W'(1);
        row_inc  = DIM_W'(row_reg) + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (load_acc) begin
            if (col_inc >= dims.w) begin
                col_next = '0;
                row_next = (row_inc >= dims.h) ? '0 : ROW_W'(row_inc);
            end else begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            negate_reg <= 1'b0;
            chan_reg   <= CHANNELS_RESET;
            width_reg  <= MAP_SIZE_RESET;
            height_reg <= MAP_SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_NEGATE: begin
                        negate_reg <= cfg_wdata[0];
                    end
                    REG_CHANNELS: begin
                        chan_reg <= cfg_wdata[CNT_W-1:0];
                    end
                    REG_WIDTH: begin
                        width_reg <= cfg_wdata[DIM_W-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_HEIGHT: begin
                        height_reg <= cfg_wdata[DIM_W-1:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ogtr_queue.sv =====
// ----------------------------------------------------------------------------
// ogtr_queue: command queue
// Short FIFO of requests between the intake front and the grid back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ogtr_queue import ogtr_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_data
);

    cmd_t              mem_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg < (CMD_AW + 1)'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ogtr_back.sv =====
// ----------------------------------------------------------------------------
// ogtr_back: grid access and tile readout
// Walks tile windows cell by cell, computes grid addresses through a
// registered multiply, writes and reads the grid RAM and buffers results in
// a credit-controlled output FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module ogtr_back import ogtr_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire map_dims_t            dims,
    input  wire logic                 q_valid,
    input  wire cmd_t                 q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic [TSIZE_W-1:0] tw_reg, tw_next, th_reg, th_next;
    logic [OFS_W-1:0]   i_reg, i_next, j_reg, j_next;
    logic [OUT_CW-1:0]  used_reg, used_next;

    logic               can_issue, issue_valid, issue_tile, col_end, row_end;
    logic [TPOS_W-1:0]  x_sum, y_sum;
    op_t                issue;

    logic               b_valid_reg, c_valid_reg;
    op_t                opb_reg, opc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [GRID_AW-1:0] addr;
    cell_code_t         rd_code;

    res_t               out_mem_reg [OUT_DEPTH];
    res_t               head, res_in;
    logic [OUT_AW-1:0]  out_wr_reg, out_rd_reg;
    logic [OUT_CW-1:0]  out_cnt_reg, out_cnt_next;
    logic               out_push, out_pop;

    assign can_issue = (used_reg < OUT_CW'(OUT_DEPTH));
    assign x_sum     = TPOS_W'(ox_reg) + TPOS_W'(i_reg);
    assign y_sum     = TPOS_W'(oy_reg) + TPOS_W'(j_reg);
    assign col_end   = (TSIZE_W'(i_reg) == tw_reg - TSIZE_W'(1));
    assign row_end   = (TSIZE_W'(j_reg) == th_reg - TSIZE_W'(1));
    assign q_pop     = q_valid && !busy_reg;
    assign issue_tile = busy_reg && can_issue;

    always_comb begin
        busy_next   = busy_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        tw_next     = tw_reg;
        th_next     = th_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        issue_valid = 1'b0;
        issue       = '0;
        if (busy_reg) begin
            if (can_issue) begin
                issue_valid    = 1'b1;
                issue.is_write = 1'b0;
                issue.code     = CELL_UNKNOWN;
                issue.x        = x_sum;
                issue.y        = y_sum;
                issue.cx       = i_reg;
                issue.cy       = j_reg;
                issue.off      = (x_sum >= TPOS_W'(dims.w)) || (y_sum >= TPOS_W'(dims.h));
                issue.last     = col_end && row_end;
                if (col_end) begin
                    i_next = '0;
                    if (row_end) begin
                        busy_next = 1'b0;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
        end else if (q_valid) begin
            if (q_data.is_tile) begin
                busy_next = 1'b1;
                ox_next   = q_data.x;
                oy_next   = q_data.y;
                tw_next   = q_data.tw;
                th_next   = q_data.th;
                i_next    = '0;
                j_next    = '0;
            end else begin
                issue_valid    = 1'b1;
                issue.is_write = 1'b1;
                issue.code     = q_data.code;
                issue.x        = TPOS_W'(q_data.x);
                issue.y        = TPOS_W'(q_data.y);
            end
        end
    end

    always_comb begin
        used_next = used_reg;
        if (issue_tile && !out_pop) begin
            used_next = used_reg + 1'b1;
        end else if (out_pop && !issue_tile) begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            used_reg    <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            used_reg    <= used_next;
            b_valid_reg <= issue_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        tw_reg   <= tw_next;
        th_reg   <= th_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        opb_reg  <= issue;
        prod_reg <= PROD_W'(dims.w) * PROD_W'(issue.y[ROW_W-1:0]);
        opc_reg  <= opb_reg;
    end

    assign addr = GRID_AW'(prod_reg) + GRID_AW'(opb_reg.x[COL_W-1:0]);

    ogtr_ram #(
        .WIDTH (2),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk     (aclk),
        .wr_en   (b_valid_reg && opb_reg.is_write),
        .wr_addr (addr),
        .wr_data (opb_reg.code),
        .rd_addr (addr),
        .rd_data (rd_code)
    );

    assign out_push     = c_valid_reg && !opc_reg.is_write;
    assign res_in.value = opc_reg.off ? CELL_UNKNOWN : rd_code;
    assign res_in.cx    = opc_reg.cx;
    assign res_in.cy    = opc_reg.cy;
    assign res_in.off   = opc_reg.off;
    assign res_in.last  = opc_reg.last;

    assign head     = out_mem_reg[out_rd_reg];
    assign m_tvalid = (out_cnt_reg != '0);
    assign out_pop  = m_tvalid && m_tready;
    assign m_tdata  = M_TDATA_W'({head.off, head.cy, head.cx, head.value});
    assign m_tlast  = head.last;

    always_comb begin
        out_cnt_next = out_cnt_reg;
        if (out_push && !out_pop) begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end else if (out_pop && !out_push) begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end else begin
            out_cnt_reg <= out_cnt_next;
            if (out_push) begin
                out_wr_reg <= (out_wr_reg == OUT_AW'(OUT_DEPTH - 1)) ? '0 : out_wr_reg + 1'b1;
            end
            if (out_pop) begin
                out_rd_reg <= (out_rd_reg == OUT_AW'(OUT_DEPTH - 1)) ? '0 : out_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            out_mem_reg[out_wr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/occupancy_grid_load_and_tile_read.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_load_and_tile_read: occupancy grid loader and tile reader
// Loads classified image pixels into a row-flipped cell grid and streams
// out windows of cells on request.
//
//   Channel  Direction  Ports                          Contents
//   s_       in         tvalid tready tdata tuser      load pixel or tile request
//   m_       out        tvalid tready tdata tlast      one cell of a tile
//   cfg_     in         wr_en index wdata              negate, channels, width, height
//
// A load request writes one grid cell; a tile request is dequeued and then
// walked cell by cell, one grid RAM read per cell. A cell result passes the
// multiply register, the RAM read register and the output FIFO.
// Reset clears control state only; grid contents stay undefined until loaded.
// An eight-entry output FIFO with credits lets m_tready stall the cell walk
// while the four-entry command queue buffers requests; s_tready falls when full.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_load_and_tile_read import ogtr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // chan0, chan1, chan2, chan3, tile_col, tile_row, tile_width, tile_height
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // cell_value, cell_x, cell_y, offmap
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    map_dims_t dims;
    cmd_t      push_data, pop_data;
    logic      push, push_ready, pop, pop_valid;

    ogtr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .dims      (dims),
        .q_push    (push),
        .q_data    (push_data),
        .q_ready   (push_ready)
    );

    ogtr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    ogtr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims),
        .q_valid  (pop_valid),
        .q_data   (pop_data),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
